// ===== design/clt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

    localparam int MAX_TOKENS    = 16;
    localparam int MAX_TOKEN_LEN = 64;

    localparam int CH_W    = 21;
    localparam int KIND_W  = 2;
    localparam int SLOTO_W = 4;
    localparam int TYPE_W  = 3;
    localparam int LENO_W  = 7;

    localparam int SLOT_W = $clog2(MAX_TOKENS);
    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int KWP_W  = 3;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // record kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

    // token types
    localparam logic [TYPE_W-1:0] TYPE_NONE    = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_COMMAND = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_STRING  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_INTEGER = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_PLAIN   = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_KEYWORD = 3'd5;

    // keyword match progress
    localparam logic [KWP_W-1:0] KWP_ZERO = 3'd0;
    localparam logic [KWP_W-1:0] KWP_FULL = 3'd3;
    localparam logic [KWP_W-1:0] KWP_MISS = 3'd4;

    // characters
    localparam logic [CH_W-1:0] CH_NUL   = 21'h0;
    localparam logic [CH_W-1:0] CH_SPACE = 21'h20;
    localparam logic [CH_W-1:0] CH_QUOTE = 21'h22;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_MID     = 3'd1,
        MODE_COMMAND = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_INTEGER = 3'd4,
        MODE_PLAIN   = 3'd5,
        MODE_DISCARD = 3'd6
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [SLOT_W-1:0]  idx;
        logic [LEN_W-1:0]   len;
        logic [TYPE_W-1:0]  typ;
        logic [KWP_W-1:0]   kwp;
    } tok_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOTO_W-1:0] slot;
        logic [CH_W-1:0]    value_char;
        logic [TYPE_W-1:0]  token_type;
        logic [LENO_W-1:0]  length;
        logic               last;
    } rec_t;

    localparam tok_state_t LINE_START = '{
        mode: MODE_START, idx: '0, len: '0, typ: TYPE_NONE, kwp: KWP_ZERO
    };

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    endfunction

    function automatic logic is_numeral(input logic [CH_W-1:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    // characters of the keyword ALL
    function automatic logic [CH_W-1:0] kw_char(input logic [KWP_W-1:0] p);
        logic [CH_W-1:0] r;
        unique case (p)
            3'd0:    r = 21'h41;
            3'd1:    r = 21'h4C;
            3'd2:    r = 21'h4C;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    function automatic logic [SLOTO_W-1:0] slot_out(input logic [SLOT_W-1:0] i);
        logic [SLOT_W+SLOTO_W-1:0] w;
        w = {{SLOTO_W{1'b0}}, i};
        return w[SLOTO_W-1:0];
    endfunction

    function automatic logic [LENO_W-1:0] len_out(input logic [LEN_W-1:0] l);
        logic [LEN_W+LENO_W-1:0] w;
        w = {{LENO_W{1'b0}}, l};
        return w[LENO_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/clt_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clt_step
    import clt_pkg::*;
(
    input  tok_state_t         st,
    input  logic [CH_W-1:0]    ch,
    output tok_state_t         st_next,
    output logic [1:0]         rec_cnt,
    output rec_t               rec0,
    output rec_t               rec1
);

    logic              do_seg;
    logic              do_store;
    logic              do_fail;
    mode_t             seg_mode;
    logic              is_sp;
    logic              is_nul;
    logic              idx_full;
    logic [TYPE_W-1:0] fin_type;
    logic [SLOT_W-1:0] idx_inc;
    logic [LEN_W-1:0]  len_inc;

    assign is_sp    = (ch == CH_SPACE);
    assign is_nul   = (ch == CH_NUL);
    assign idx_full = ({1'b0, st.idx} + (SLOT_W+1)'(1)) >= (SLOT_W+1)'(MAX_TOKENS);
    assign fin_type = (st.typ == TYPE_PLAIN && st.kwp == KWP_FULL) ? TYPE_KEYWORD : st.typ;
    assign idx_inc  = st.idx + SLOT_W'(1);

    always_comb begin
        st_next  = st;
        rec_cnt  = 2'd0;
        rec0     = '0;
        rec1     = '0;
        do_seg   = 1'b0;
        do_store = 1'b0;
        do_fail  = 1'b0;
        seg_mode = MODE_MID;
        len_inc  = st.len + LEN_W'(1);

        unique case (st.mode)
            MODE_DISCARD: begin
                if (is_nul) begin
                    st_next = LINE_START;
                end
            end
            MODE_COMMAND: begin
                if (is_letter(ch)) begin
                    do_store = 1'b1;
                end else begin
                    do_seg = 1'b1;
                end
            end
            MODE_STRING: begin
                if (ch == CH_QUOTE) begin
                    st_next.mode = MODE_MID;
                end else if (is_nul) begin
                    do_fail = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
            MODE_INTEGER: begin
                if (is_numeral(ch)) begin
                    do_store = 1'b1;
                end else if (is_sp || is_nul) begin
                    do_seg = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            MODE_PLAIN: begin
                if (is_sp || is_nul) begin
                    do_seg = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
            MODE_MID: begin
                do_seg = 1'b1;
            end
            default: begin
                do_seg   = 1'b1;
                seg_mode = MODE_START;
            end
        endcase

        // first character of a segment
        if (do_seg) begin
            st_next.mode = seg_mode;
            if (is_sp || is_nul) begin
                if (idx_full) begin
                    do_fail = 1'b1;
                end else begin
                    rec0.kind       = KIND_END;
                    rec0.slot       = slot_out(st.idx);
                    rec0.token_type = fin_type;
                    rec0.length     = len_out(st.len);
                    rec_cnt         = 2'd1;
                    if (is_nul) begin
                        rec1.kind = KIND_EOL;
                        rec1.slot = slot_out(idx_inc);
                        rec1.last = 1'b1;
                        rec_cnt   = 2'd2;
                        st_next   = LINE_START;
                    end else begin
                        st_next.idx = idx_inc;
                        st_next.len = '0;
                        st_next.typ = TYPE_NONE;
                        st_next.kwp = KWP_ZERO;
                    end
                end
            end else if (seg_mode == MODE_START) begin
                if (is_letter(ch)) begin
                    st_next.typ  = TYPE_COMMAND;
                    st_next.mode = MODE_COMMAND;
                    do_store     = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end else if (ch == CH_QUOTE) begin
                st_next.typ  = TYPE_STRING;
                st_next.mode = MODE_STRING;
            end else if (is_numeral(ch)) begin
                st_next.typ  = TYPE_INTEGER;
                st_next.mode = MODE_INTEGER;
                do_store     = 1'b1;
            end else begin
                st_next.typ  = TYPE_PLAIN;
                st_next.mode = MODE_PLAIN;
                do_store     = 1'b1;
            end
        end

        if (do_store) begin
            if (st.len >= LEN_W'(MAX_TOKEN_LEN)) begin
                do_fail = 1'b1;
            end else begin
                st_next.len = len_inc;
                if (st.kwp < KWP_FULL && ch == kw_char(st.kwp)) begin
                    st_next.kwp = st.kwp + KWP_W'(1);
                end else begin
                    st_next.kwp = KWP_MISS;
                end
                rec0.kind       = KIND_CHAR;
                rec0.slot       = slot_out(st.idx);
                rec0.value_char = ch;
                rec0.token_type = st_next.typ;
                rec0.length     = len_out(len_inc);
                rec_cnt         = 2'd1;
            end
        end

        if (do_fail) begin
            rec0      = '0;
            rec0.kind = KIND_ERR;
            rec0.last = 1'b1;
            rec1      = '0;
            rec_cnt   = 2'd1;
            if (is_nul) begin
                st_next = LINE_START;
            end else begin
                st_next.mode = MODE_DISCARD;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/clt_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clt_outq
    import clt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  push_cnt,
    input  rec_t        push0,
    input  rec_t        push1,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output rec_t        out_rec
);

    rec_t                 mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_CNT_W-1:0]  count_reg, count_next;
    logic [OQ_PTR_W-1:0]  wr_ptr_inc;
    logic                 pop;

    // two free entries cover the worst case of one item
    assign room       = count_reg <= OQ_CNT_W'(OQ_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_rec    = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + OQ_PTR_W'(1);

    always_comb begin
        rd_ptr_next = pop ? rd_ptr_reg + OQ_PTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push_cnt);
        count_next  = count_reg + OQ_CNT_W'(push_cnt) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue count above depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> room)
        else $error("output queue written without room");

    a_pop_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push_cnt == 2'd0 |=> count_reg == $past(count_reg) - OQ_CNT_W'(1))
        else $error("output queue lost track of a transfer");

endmodule

`default_nettype wire

// ===== design/command_line_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                                         transfer when
// input     in         s_valid s_ready s_ch                          s_valid && s_ready
// result    out        m_valid m_ready m_kind m_slot m_value_char    m_valid && m_ready
//                      m_token_type m_length m_last
//
// one character per cycle while s_ready is high; the tokenizer state updates in the same
// cycle the character is taken, and its zero, one or two records land in a four-entry
// output queue; a completed line end pushes an END and an EOL record
// s_ready is high while the queue has at least two free entries, so stalls on m_ready
// back up into s_ready once the queue holds more than two records
// aresetn (synchronous) returns to the start of a line and empties the queue

module command_line_tokenizer_core
    import clt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CH_W-1:0]      s_ch,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [SLOTO_W-1:0]   m_slot,
    output logic [CH_W-1:0]      m_value_char,
    output logic [TYPE_W-1:0]    m_token_type,
    output logic [LENO_W-1:0]    m_length,
    output logic                 m_last
);

    tok_state_t  st_reg, st_next;
    tok_state_t  step_st;
    logic [1:0]  step_cnt;
    logic [1:0]  push_cnt;
    rec_t        rec0, rec1;
    rec_t        head;
    logic        room;
    logic        s_xfer;

    assign s_ready  = room;
    assign s_xfer   = s_valid && s_ready;
    assign push_cnt = s_xfer ? step_cnt : 2'd0;
    assign st_next  = s_xfer ? step_st : st_reg;

    clt_step u_step (
        .st      (st_reg),
        .ch      (s_ch),
        .st_next (step_st),
        .rec_cnt (step_cnt),
        .rec0    (rec0),
        .rec1    (rec1)
    );

    clt_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (rec0),
        .push1     (rec1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= LINE_START;
        end else begin
            st_reg <= st_next;
        end
    end

    assign m_kind       = head.kind;
    assign m_slot       = head.slot;
    assign m_value_char = head.value_char;
    assign m_token_type = head.token_type;
    assign m_length     = head.length;
    assign m_last       = head.last;

    a_err_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERR |-> m_last && m_slot == '0 && m_length == '0)
        else $error("malformed error record");

    a_eol_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_CHAR || m_kind == KIND_END) |-> !m_last)
        else $error("last set on a mid-line record");

    a_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_ch == CH_NUL |=> st_reg.mode == MODE_START && st_reg.idx == '0)
        else $error("line end did not restart the line");

endmodule

`default_nettype wire

// ===== dv/clt_token_checker.sv =====
`timescale 1ns / 1ps

module clt_token_checker
    import clt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [CH_W-1:0]     s_ch,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [KIND_W-1:0]   m_kind,
    input  logic [SLOTO_W-1:0]  m_slot,
    input  logic [CH_W-1:0]     m_value_char,
    input  logic [TYPE_W-1:0]   m_token_type,
    input  logic [LENO_W-1:0]   m_length,
    input  logic                m_last,
    output int                  mismatches,
    output int                  pending,
    output int                  live_chars,
    output int                  lines_done,
    output int                  errors_seen,
    output int                  records_checked
);

    localparam logic [CH_W-1:0] CH_A = 21'h41;
    localparam logic [CH_W-1:0] CH_L = 21'h4C;

    // tokenizer state as predicted
    mode_t              cur_mode;
    int                 cur_slot;
    int                 cur_len;
    logic [TYPE_W-1:0]  cur_type;
    logic [KWP_W-1:0]   kw_pos;

    rec_t exp_records[$];
    rec_t got;
    rec_t want;

    int bad_cnt = 0;
    int chars_cnt = 0;
    int eol_cnt = 0;
    int err_cnt = 0;
    int rec_cnt = 0;

    function automatic logic is_ascii_letter(input logic [CH_W-1:0] c);
        return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    endfunction

    function automatic logic is_decimal(input logic [CH_W-1:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic [TYPE_W-1:0] closing_type();
        if (cur_type == TYPE_PLAIN && kw_pos == KWP_FULL)
            return TYPE_KEYWORD;
        return cur_type;
    endfunction

    task automatic emit(input logic [KIND_W-1:0] k, input int s, input logic [CH_W-1:0] vc,
                        input logic [TYPE_W-1:0] t, input int n, input logic lst);
        rec_t r;
        r.kind       = k;
        r.slot       = s[SLOTO_W-1:0];
        r.value_char = vc;
        r.token_type = t;
        r.length     = n[LENO_W-1:0];
        r.last       = lst;
        exp_records.push_back(r);
    endtask

    task automatic open_slot();
        cur_len  = 0;
        cur_type = TYPE_NONE;
        kw_pos   = KWP_ZERO;
    endtask

    task automatic line_restart();
        cur_mode = MODE_START;
        cur_slot = 0;
        open_slot();
    endtask

    task automatic abort(input logic [CH_W-1:0] c);
        emit(KIND_ERR, 0, CH_NUL, TYPE_NONE, 0, 1'b1);
        if (c == CH_NUL)
            line_restart();
        else
            cur_mode = MODE_DISCARD;
    endtask

    task automatic put_char(input logic [CH_W-1:0] c);
        if (cur_len >= MAX_TOKEN_LEN) begin
            abort(c);
        end else begin
            cur_len++;
            if (kw_pos < KWP_FULL && c == ((kw_pos == KWP_ZERO) ? CH_A : CH_L))
                kw_pos = kw_pos + 1'b1;
            else
                kw_pos = KWP_MISS;
            emit(KIND_CHAR, cur_slot, c, cur_type, cur_len, 1'b0);
        end
    endtask

    // first character of a segment, in start or mid mode
    task automatic segment(input logic [CH_W-1:0] c);
        if (c == CH_SPACE || c == CH_NUL) begin
            if (cur_slot + 1 >= MAX_TOKENS) begin
                abort(c);
            end else begin
                emit(KIND_END, cur_slot, CH_NUL, closing_type(), cur_len, 1'b0);
                if (c == CH_NUL) begin
                    emit(KIND_EOL, cur_slot + 1, CH_NUL, TYPE_NONE, 0, 1'b1);
                    line_restart();
                end else begin
                    cur_slot++;
                    open_slot();
                end
            end
        end else if (cur_mode == MODE_START) begin
            if (!is_ascii_letter(c)) begin
                abort(c);
            end else begin
                cur_type = TYPE_COMMAND;
                cur_mode = MODE_COMMAND;
                put_char(c);
            end
        end else if (c == CH_QUOTE) begin
            cur_type = TYPE_STRING;
            cur_mode = MODE_STRING;
        end else if (is_decimal(c)) begin
            cur_type = TYPE_INTEGER;
            cur_mode = MODE_INTEGER;
            put_char(c);
        end else begin
            cur_type = TYPE_PLAIN;
            cur_mode = MODE_PLAIN;
            put_char(c);
        end
    endtask

    task automatic tokenize(input logic [CH_W-1:0] c);
        case (cur_mode)
            MODE_DISCARD: begin
                if (c == CH_NUL)
                    line_restart();
            end
            MODE_COMMAND: begin
                if (is_ascii_letter(c)) begin
                    put_char(c);
                end else begin
                    cur_mode = MODE_MID;
                    segment(c);
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE)
                    cur_mode = MODE_MID;
                else if (c == CH_NUL)
                    abort(c);
                else
                    put_char(c);
            end
            MODE_INTEGER: begin
                if (is_decimal(c)) begin
                    put_char(c);
                end else if (c == CH_SPACE || c == CH_NUL) begin
                    cur_mode = MODE_MID;
                    segment(c);
                end else begin
                    abort(c);
                end
            end
            MODE_PLAIN: begin
                if (c == CH_SPACE || c == CH_NUL) begin
                    cur_mode = MODE_MID;
                    segment(c);
                end else begin
                    put_char(c);
                end
            end
            MODE_MID: segment(c);
            default: begin
                cur_mode = MODE_START;
                segment(c);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            exp_records.delete();
            line_restart();
        end else begin
            // compare before predicting: a record never shows in its own transfer cycle
            if (m_valid && m_ready) begin
                got.kind       = m_kind;
                got.slot       = m_slot;
                got.value_char = m_value_char;
                got.token_type = m_token_type;
                got.length     = m_length;
                got.last       = m_last;
                rec_cnt++;
                if (got.kind == KIND_EOL)
                    eol_cnt++;
                if (got.kind == KIND_ERR)
                    err_cnt++;
                if (exp_records.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("unexpected record: kind %0d slot %0d char %h type %0d len %0d",
                                 got.kind, got.slot, got.value_char, got.token_type,
                                 got.length);
                end else begin
                    want = exp_records.pop_front();
                    if (got.kind != want.kind || got.slot != want.slot ||
                        got.value_char != want.value_char ||
                        got.token_type != want.token_type ||
                        got.length != want.length || got.last != want.last) begin
                        bad_cnt++;
                        if (bad_cnt <= 10) begin
                            $display({"mismatch expected: kind %0d slot %0d char %h type %0d",
                                      " len %0d last %0d"},
                                     want.kind, want.slot, want.value_char, want.token_type,
                                     want.length, want.last);
                            $display({"           actual: kind %0d slot %0d char %h type %0d",
                                      " len %0d last %0d"},
                                     got.kind, got.slot, got.value_char, got.token_type,
                                     got.length, got.last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (cur_mode != MODE_DISCARD)
                    chars_cnt++;
                tokenize(s_ch);
            end
        end
        mismatches      <= bad_cnt;
        pending         <= exp_records.size();
        live_chars      <= chars_cnt;
        lines_done      <= eol_cnt;
        errors_seen     <= err_cnt;
        records_checked <= rec_cnt;
    end

endmodule

// ===== dv/command_line_tokenizer_core_test.sv =====
`timescale 1ns / 1ps

module command_line_tokenizer_core_test;
    import clt_pkg::*;

    localparam int LIVE_TARGET = 950;
    localparam int CALM_FROM   = 800;
    localparam int STALL_LIMIT = 2000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CH_W-1:0]     s_ch = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [KIND_W-1:0]   m_kind;
    logic [SLOTO_W-1:0]  m_slot;
    logic [CH_W-1:0]     m_value_char;
    logic [TYPE_W-1:0]   m_token_type;
    logic [LENO_W-1:0]   m_length;
    logic                m_last;

    int mismatches;
    int pending;
    int live_chars;
    int lines_done;
    int errors_seen;
    int records_checked;
    int quiet_cycles = 0;
    logic calm = 1'b0;

    logic [CH_W-1:0] line_buf[$];

    command_line_tokenizer_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_slot       (m_slot),
        .m_value_char (m_value_char),
        .m_token_type (m_token_type),
        .m_length     (m_length),
        .m_last       (m_last)
    );

    clt_token_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_slot          (m_slot),
        .m_value_char    (m_value_char),
        .m_token_type    (m_token_type),
        .m_length        (m_length),
        .m_last          (m_last),
        .mismatches      (mismatches),
        .pending         (pending),
        .live_chars      (live_chars),
        .lines_done      (lines_done),
        .errors_seen     (errors_seen),
        .records_checked (records_checked)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d records outstanding",
                     quiet_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a clock edge; returns at the edge where the transfer happens
    task automatic send_char(input logic [CH_W-1:0] c);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char({13'd0, txt[i]});
    endtask

    function automatic logic [CH_W-1:0] letter();
        logic [CH_W-1:0] c;
        c = $urandom_range(0, 1) ? CH_W'($urandom_range(32'h41, 32'h5A))
                                 : CH_W'($urandom_range(32'h61, 32'h7A));
        return c;
    endfunction

    function automatic logic [CH_W-1:0] digit();
        logic [CH_W-1:0] c;
        c = CH_W'($urandom_range(32'h30, 32'h39));
        return c;
    endfunction

    // never a space or a line end
    function automatic logic [CH_W-1:0] pick_char();
        logic [CH_W-1:0] c;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            c = CH_W'($urandom_range(32'h21, 32'h7E));
        else if (r < 9)
            c = CH_W'($urandom_range(32'h80, 32'h10FFFF));
        else
            c = CH_W'($urandom_range(1, 32'h1F));
        return c;
    endfunction

    function automatic logic [CH_W-1:0] noise_char();
        logic [CH_W-1:0] c;
        case ($urandom_range(0, 5))
            0: c = CH_SPACE;
            1: c = CH_QUOTE;
            2: c = digit();
            3: c = letter();
            default: c = pick_char();
        endcase
        return c;
    endfunction

    task automatic add_segment();
        int n;
        logic [CH_W-1:0] c;
        n = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 5);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                line_buf.push_back(CH_QUOTE);
                if ($urandom_range(0, 5) == 0)
                    n = 0;
                repeat (n) begin
                    c = ($urandom_range(0, 4) == 0) ? CH_SPACE : pick_char();
                    if (c == CH_QUOTE)
                        c = letter();
                    line_buf.push_back(c);
                end
                // left open now and then
                if ($urandom_range(0, 7) != 0)
                    line_buf.push_back(CH_QUOTE);
            end
            3, 4: begin
                repeat (n) line_buf.push_back(digit());
                if ($urandom_range(0, 7) == 0)
                    line_buf.push_back(letter());
            end
            5, 6, 7: begin
                repeat (n) line_buf.push_back(pick_char());
            end
            default: begin
                line_buf.push_back(21'h41);
                line_buf.push_back(21'h4C);
                case ($urandom_range(0, 3))
                    0, 1: line_buf.push_back(21'h4C);
                    2: ;
                    default: begin
                        line_buf.push_back(21'h4C);
                        line_buf.push_back(pick_char());
                    end
                endcase
            end
        endcase
    endtask

    task automatic build_line();
        int n;
        int segs;
        int style;
        line_buf.delete();
        style = $urandom_range(0, 19);
        if (style == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(noise_char());
        end else begin
            n = (style == 1) ? $urandom_range(62, 66) : $urandom_range(1, 6);
            repeat (n) line_buf.push_back(letter());
            segs = (style == 2) ? $urandom_range(13, 17) : $urandom_range(0, 5);
            repeat (segs) begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: repeat ($urandom_range(2, 3)) line_buf.push_back(CH_SPACE);
                    default: line_buf.push_back(CH_SPACE);
                endcase
                add_segment();
            end
            if ($urandom_range(0, 5) == 0)
                line_buf.push_back(CH_SPACE);
        end
        line_buf.push_back(CH_NUL);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // command, string with a space, integer touching it, empty slot, keyword
        send_text("Az \"a b\"7  ALL");
        send_char(CH_NUL);
        // empty line
        send_char(CH_NUL);
        // command starting with a digit, rest of the line dropped
        send_text("1x");
        send_char(CH_NUL);
        // string open at the line end, top of the character range inside
        send_text("q\"");
        send_char(21'h10FFFF);
        send_char(CH_NUL);
        // digits running into a letter
        send_text("x 12a");
        send_char(CH_NUL);

        while (live_chars < LIVE_TARGET) begin
            calm <= (live_chars >= CALM_FROM);
            build_line();
            foreach (line_buf[i])
                send_char(line_buf[i]);
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (16) @(posedge aclk);

        $display("%0d characters tokenized over %0d completed lines", live_chars, lines_done);
        $display("%0d records checked, %0d of them error records, %0d mismatches",
                 records_checked, errors_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
